// File: rtl/umt_pkg.sv
package umt_pkg;

	// Configuration register indexes.
	localparam logic [2:0] CFG_REG_BASE    = 3'd0;
	localparam logic [2:0] CFG_HALT_CODE   = 3'd1;
	localparam logic [2:0] CFG_OUTPUT_CODE = 3'd2;
	localparam logic [2:0] CFG_INPUT_CODE  = 3'd3;
	localparam logic [2:0] CFG_SERVICE_REG = 3'd4;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 5;

	// Reset values of the configuration registers.
	localparam logic [4:0] RST_REG_BASE    = 5'd19;
	localparam logic [2:0] RST_HALT_CODE   = 3'd0;
	localparam logic [2:0] RST_OUTPUT_CODE = 3'd1;
	localparam logic [2:0] RST_INPUT_CODE  = 3'd2;
	localparam logic [4:0] RST_SERVICE_REG = 5'd1;

	// UM opcodes.
	localparam logic [3:0] OP_CMOV   = 4'd0;
	localparam logic [3:0] OP_ALOAD  = 4'd1;
	localparam logic [3:0] OP_ASTORE = 4'd2;
	localparam logic [3:0] OP_ADD    = 4'd3;
	localparam logic [3:0] OP_MUL    = 4'd4;
	localparam logic [3:0] OP_DIV    = 4'd5;
	localparam logic [3:0] OP_NAND   = 4'd6;
	localparam logic [3:0] OP_HALT   = 4'd7;
	localparam logic [3:0] OP_MAP    = 4'd8;
	localparam logic [3:0] OP_UNMAP  = 4'd9;
	localparam logic [3:0] OP_OUTPUT = 4'd10;
	localparam logic [3:0] OP_INPUT  = 4'd11;
	localparam logic [3:0] OP_LOADP  = 4'd12;
	localparam logic [3:0] OP_LOADV  = 4'd13;

	// Host instruction templates.
	localparam logic [31:0] NOP_WORD      = 32'hD503_201F;
	localparam logic [31:0] MOVZ_W        = 32'h5280_0000;
	localparam logic [31:0] MOVK_W_HI     = 32'h72A0_0000;
	localparam logic [31:0] CMP_W_ZERO    = 32'h7100_001F;
	localparam logic [31:0] CSEL_W        = 32'h1A80_0000;
	localparam logic [31:0] ADD_X_BASE    = 32'h8B00_0389;
	localparam logic [31:0] LDR_W_IDX     = 32'hB860_5920;
	localparam logic [31:0] STR_W_IDX     = 32'hB820_5920;
	localparam logic [31:0] ADD_W         = 32'h0B00_0000;
	localparam logic [31:0] MADD_W        = 32'h1B00_0000;
	localparam logic [31:0] UDIV_W        = 32'h1AC0_0800;
	localparam logic [31:0] AND_W         = 32'h0A00_0000;
	localparam logic [31:0] MVN_W         = 32'h2A20_03E0;
	localparam logic [31:0] MOV_W         = 32'h2A00_03E0;
	localparam logic [31:0] MOV_W10       = 32'h2A00_03EA;
	localparam logic [31:0] BR_X15        = 32'hD61F_01E0;
	localparam logic [31:0] BLR_X12       = 32'hD63F_0180;
	localparam logic [31:0] BLR_X13       = 32'hD63F_01A0;
	localparam logic [31:0] BLR_X15       = 32'hD63F_01E0;
	localparam logic [4:0]  SCRATCH_REG   = 5'd9;
	localparam logic [4:0]  ZERO_REG      = 5'd31;

	localparam int QUEUE_DEPTH = 2;

	// Configuration seen by the decode and encode parts.
	typedef struct packed {
		logic [4:0] reg_base;
		logic [2:0] halt_code;
		logic [2:0] output_code;
		logic [2:0] input_code;
		logic [4:0] service_reg;
	} cfg_t;

	// One classified UM instruction.
	typedef struct packed {
		logic [3:0]  op;
		logic [4:0]  ra;
		logic [4:0]  rb;
		logic [4:0]  rc;
		logic [24:0] imm;
	} decoded_t;

	// Host register that a UM register maps onto, modulo 32.
	function automatic logic [4:0] host_reg(input logic [4:0] base, input logic [2:0] x);
		host_reg = base + {2'b00, x};
	endfunction

endpackage

// File: rtl/umt_if.sv
interface umt_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] um_word;

	modport source (output valid, output um_word, input ready);
	modport sink (input valid, input um_word, output ready);
endinterface

interface umt_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] host_word_first;
	logic [31:0] host_word_second;
	logic [31:0] host_word_third;

	modport source (output valid, output host_word_first, output host_word_second,
		output host_word_third, input ready);
	modport sink (input valid, input host_word_first, input host_word_second,
		input host_word_third, output ready);
endinterface

// File: rtl/umt_front.sv
module umt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  umt_pkg::cfg_t     cfg,
	umt_in_if.sink            um_in,
	output logic              dec_valid,
	input  logic              dec_ready,
	output umt_pkg::decoded_t dec
);
	import umt_pkg::*;

	logic     valid_s1;
	decoded_t dec_s1;
	decoded_t dec_next;
	logic     accept;

	// The stage takes a new word when empty or when its content moves on.
	assign um_in.ready = !valid_s1 || dec_ready;
	assign accept      = um_in.valid && um_in.ready;

	// Split the word into opcode, mapped host registers and immediate.
	always_comb begin
		dec_next.op  = um_in.um_word[31:28];
		dec_next.rb  = host_reg(cfg.reg_base, um_in.um_word[5:3]);
		dec_next.rc  = host_reg(cfg.reg_base, um_in.um_word[2:0]);
		dec_next.imm = um_in.um_word[24:0];
		if (um_in.um_word[31:28] == OP_LOADV) begin
			dec_next.ra = host_reg(cfg.reg_base, um_in.um_word[27:25]);
		end else begin
			dec_next.ra = host_reg(cfg.reg_base, um_in.um_word[8:6]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (um_in.ready) begin
			valid_s1 <= um_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dec_s1 <= dec_next;
		end
	end

	assign dec_valid = valid_s1;
	assign dec       = dec_s1;

endmodule

// File: rtl/umt_queue.sv
module umt_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  umt_pkg::decoded_t push_data,
	output logic              pop_valid,
	input  logic              pop_ready,
	output umt_pkg::decoded_t pop_data
);
	import umt_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	decoded_t           entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               push;
	logic               pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = entry_q[rd_ptr_q];

	// Pointers wrap at the queue depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 1'b1))
		else $error("queue count missed a push");
	a_count_down: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !push) |=> (count_q == $past(count_q) - 1'b1))
		else $error("queue count missed a pop");
`endif

endmodule

// File: rtl/umt_back.sv
module umt_back (
	input  logic              clk,
	input  logic              arst_n,
	input  umt_pkg::cfg_t     cfg,
	input  logic              dec_valid,
	output logic              dec_ready,
	input  umt_pkg::decoded_t dec,
	umt_out_if.source         host_out
);
	import umt_pkg::*;

	logic        valid_q;
	logic [31:0] w0_q;
	logic [31:0] w1_q;
	logic [31:0] w2_q;
	logic [31:0] w0;
	logic [31:0] w1;
	logic [31:0] w2;
	logic [31:0] ra;
	logic [31:0] rb;
	logic [31:0] rc;
	logic [31:0] svc_reg;

	assign ra      = {27'd0, dec.ra};
	assign rb      = {27'd0, dec.rb};
	assign rc      = {27'd0, dec.rc};
	assign svc_reg = {27'd0, cfg.service_reg};

	// The output register takes a new chunk when empty or being drained.
	assign dec_ready = !valid_q || host_out.ready;

	// Encode the three host words from the classified instruction.
	always_comb begin
		w0 = '0;
		w1 = '0;
		w2 = NOP_WORD;
		case (dec.op)
			OP_LOADV: begin
				w0 = MOVZ_W | {11'd0, dec.imm[15:0], 5'd0} | ra;
				w1 = MOVK_W_HI | {18'd0, dec.imm[24:16], 5'd0} | ra;
			end
			OP_CMOV: begin
				w0 = CMP_W_ZERO | (rc << 5);
				w1 = CSEL_W | ra | (rb << 5) | (ra << 16) | 32'h0000_1000;
			end
			OP_ALOAD: begin
				w0 = ADD_X_BASE | (rb << 16);
				w1 = LDR_W_IDX | ra | (rc << 16);
			end
			OP_ASTORE: begin
				w0 = ADD_X_BASE | (ra << 16);
				w1 = STR_W_IDX | rc | (rb << 16);
			end
			OP_ADD: begin
				w0 = ADD_W | ra | (rb << 5) | (rc << 16);
				w1 = NOP_WORD;
			end
			OP_MUL: begin
				w0 = MADD_W | ra | (rb << 5) | (rc << 16) | ({27'd0, ZERO_REG} << 10);
				w1 = NOP_WORD;
			end
			OP_DIV: begin
				w0 = UDIV_W | ra | (rb << 5) | (rc << 16);
				w1 = NOP_WORD;
			end
			OP_NAND: begin
				w0 = AND_W | {27'd0, SCRATCH_REG} | (rb << 5) | (rc << 16);
				w1 = MVN_W | ra | ({27'd0, SCRATCH_REG} << 16);
			end
			OP_HALT: begin
				w0 = MOVZ_W | {24'd0, cfg.halt_code, 5'd0} | svc_reg;
				w1 = BR_X15;
				w2 = '0;
			end
			OP_MAP: begin
				w0 = MOV_W | (rc << 16);
				w1 = BLR_X12;
				w2 = MOV_W | rb;
			end
			OP_UNMAP: begin
				w0 = MOV_W | (rc << 16);
				w1 = BLR_X13;
			end
			OP_OUTPUT: begin
				w0 = MOV_W | (rc << 16);
				w1 = MOVZ_W | {24'd0, cfg.output_code, 5'd0} | svc_reg;
				w2 = BLR_X15;
			end
			OP_INPUT: begin
				w0 = MOVZ_W | {24'd0, cfg.input_code, 5'd0} | svc_reg;
				w1 = BLR_X15;
				w2 = MOV_W | rc;
			end
			OP_LOADP: begin
				w0 = MOV_W10 | (rc << 16);
				w1 = MOV_W | (rb << 16);
				w2 = BR_X15;
			end
			default: begin
				// Invalid opcodes give an all-zero chunk.
				w2 = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (dec_ready) begin
			valid_q <= dec_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (dec_ready && dec_valid) begin
			w0_q <= w0;
			w1_q <= w1;
			w2_q <= w2;
		end
	end

	assign host_out.valid            = valid_q;
	assign host_out.host_word_first  = w0_q;
	assign host_out.host_word_second = w1_q;
	assign host_out.host_word_third  = w2_q;

endmodule

// File: rtl/um_to_arm64_instruction_translator.sv
// UM to AArch64 instruction translator.
// The um_in channel takes one UM instruction word per transaction (valid and
// ready both high at a rising edge). The host_out channel returns one chunk of
// three AArch64 words per transaction, in the order the words were taken.
// A front stage splits each word into opcode, mapped host registers and
// immediate; a two-entry queue separates it from the back stage, which
// builds the three words into an output register.
// Each word passes the front stage, a queue entry and the output register.
// One word per cycle is taken while host_out is not stalled; the front stage
// and output register hold one item, the queue two; each moves when next frees.
// When the receiver stalls, the output register holds its chunk, the queue
// and the front stage fill, and um_in.ready falls once four words are held.
// The configuration port writes register cfg_index with cfg_data when cfg_we
// is high; indexes beyond the register list are ignored. Write it only while
// the block holds no transaction.
// Reset clears every stage and loads the configuration registers with their
// default values; the block is ready as soon as reset is released.
module um_to_arm64_instruction_translator (
	input  logic                             clk,
	input  logic                             arst_n,
	umt_in_if.sink                           um_in,
	umt_out_if.source                        host_out,
	input  logic                             cfg_we,
	input  logic [umt_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [umt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import umt_pkg::*;

	cfg_t     cfg_q;
	logic     front_valid;
	logic     front_ready;
	decoded_t front_dec;
	logic     back_valid;
	logic     back_ready;
	decoded_t back_dec;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reg_base    <= RST_REG_BASE;
			cfg_q.halt_code   <= RST_HALT_CODE;
			cfg_q.output_code <= RST_OUTPUT_CODE;
			cfg_q.input_code  <= RST_INPUT_CODE;
			cfg_q.service_reg <= RST_SERVICE_REG;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REG_BASE:    cfg_q.reg_base    <= cfg_data[4:0];
				CFG_HALT_CODE:   cfg_q.halt_code   <= cfg_data[2:0];
				CFG_OUTPUT_CODE: cfg_q.output_code <= cfg_data[2:0];
				CFG_INPUT_CODE:  cfg_q.input_code  <= cfg_data[2:0];
				CFG_SERVICE_REG: cfg_q.service_reg <= cfg_data[4:0];
				default: begin
				end
			endcase
		end
	end

	umt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.um_in     (um_in),
		.dec_valid (front_valid),
		.dec_ready (front_ready),
		.dec       (front_dec)
	);

	umt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_data  (front_dec),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_data   (back_dec)
	);

	umt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.dec_valid (back_valid),
		.dec_ready (back_ready),
		.dec       (back_dec),
		.host_out  (host_out)
	);

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

	// AArch64 templates for the expected host words.
	localparam logic [31:0] HW_NOP      = 32'hD503_201F;
	localparam logic [31:0] HW_MOVZ     = 32'h5280_0000;
	localparam logic [31:0] HW_MOVK     = 32'h72A0_0000;
	localparam logic [31:0] HW_CMP0     = 32'h7100_001F;
	localparam logic [31:0] HW_CSEL     = 32'h1A80_0000;
	localparam logic [31:0] HW_ADDX     = 32'h8B00_0389;
	localparam logic [31:0] HW_LDR      = 32'hB860_5920;
	localparam logic [31:0] HW_STR      = 32'hB820_5920;
	localparam logic [31:0] HW_ADD      = 32'h0B00_0000;
	localparam logic [31:0] HW_MADD     = 32'h1B00_0000;
	localparam logic [31:0] HW_UDIV     = 32'h1AC0_0800;
	localparam logic [31:0] HW_AND      = 32'h0A00_0000;
	localparam logic [31:0] HW_MVN      = 32'h2A20_03E0;
	localparam logic [31:0] HW_MOV      = 32'h2A00_03E0;
	localparam logic [31:0] HW_MOV_W10  = 32'h2A00_03EA;
	localparam logic [31:0] HW_BR_X15   = 32'hD61F_01E0;
	localparam logic [31:0] HW_BLR_X12  = 32'hD63F_0180;
	localparam logic [31:0] HW_BLR_X13  = 32'hD63F_01A0;
	localparam logic [31:0] HW_BLR_X15  = 32'hD63F_01E0;
	localparam logic [31:0] HR_SCRATCH  = 32'd9;

	localparam logic [2:0] CFG_FIRST_UNUSED = 3'd5;

	localparam int IDLE_LIMIT  = 4000;
	localparam int HOLD_AT     = 300;
	localparam int HOLD_CYCLES = 160;
	localparam int REPORT_MAX  = 10;
	localparam int PHASES      = 10;
	localparam int PHASE_ITEMS = 73;

	typedef struct packed {
		logic [31:0] um_word;
		logic [31:0] first;
		logic [31:0] second;
		logic [31:0] third;
	} host_chunk_t;

	logic                             clk       = 1'b0;
	logic                             arst_n    = 1'b0;
	logic                             in_valid  = 1'b0;
	logic [31:0]                      in_word   = '0;
	logic                             out_ready = 1'b0;
	logic                             cfg_we    = 1'b0;
	logic [umt_pkg::CFG_INDEX_W-1:0]  cfg_index = '0;
	logic [umt_pkg::CFG_DATA_W-1:0]   cfg_data  = '0;

	// Local copy of the translator configuration, starting at reset values.
	umt_pkg::cfg_t cfg_model = {5'd19, 3'd0, 3'd1, 3'd2, 5'd1};

	logic [31:0]  um_words_pending [$];
	host_chunk_t  host_chunks_due [$];

	int unsigned  send_gap     = 0;
	int unsigned  send_calm    = 0;
	int unsigned  recv_stall   = 0;
	int unsigned  recv_calm    = 0;
	int unsigned  quiet_cycles = 0;
	int unsigned  words_taken  = 0;
	int unsigned  results_seen = 0;
	int unsigned  settings_used = 0;
	int unsigned  errors       = 0;
	logic         held_off     = 1'b0;

	umt_in_if  um_in ();
	umt_out_if host_out ();

	assign um_in.valid    = in_valid;
	assign um_in.um_word  = in_word;
	assign host_out.ready = out_ready;

	um_to_arm64_instruction_translator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.um_in     (um_in),
		.host_out  (host_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Host register for a UM register field, wrapping modulo 32.
	function automatic logic [31:0] map_reg(input logic [4:0] base, input logic [2:0] x);
		logic [4:0] r;
		r = base + {2'b00, x};
		return {27'd0, r};
	endfunction

	// Move of a service code into the service register.
	function automatic logic [31:0] service_mov(input logic [2:0] code, input logic [4:0] rd);
		return HW_MOVZ | {24'd0, code, 5'd0} | {27'd0, rd};
	endfunction

	// Expected three-word chunk for one UM word under a given configuration.
	function automatic host_chunk_t translate_um(input logic [31:0] w, input umt_pkg::cfg_t c);
		host_chunk_t ch;
		logic [31:0] ra, rb, rc, rl;
		ra = map_reg(c.reg_base, w[8:6]);
		rb = map_reg(c.reg_base, w[5:3]);
		rc = map_reg(c.reg_base, w[2:0]);
		rl = map_reg(c.reg_base, w[27:25]);
		ch.um_word = w;
		ch.first   = '0;
		ch.second  = '0;
		ch.third   = '0;
		case (w[31:28])
			umt_pkg::OP_LOADV: begin
				ch.first  = HW_MOVZ | {11'd0, w[15:0], 5'd0} | rl;
				ch.second = HW_MOVK | {18'd0, w[24:16], 5'd0} | rl;
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_CMOV: begin
				ch.first  = HW_CMP0 | (rc << 5);
				ch.second = HW_CSEL | ra | (rb << 5) | (ra << 16) | (32'd1 << 12);
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_ALOAD: begin
				ch.first  = HW_ADDX | (rb << 16);
				ch.second = HW_LDR | ra | (rc << 16);
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_ASTORE: begin
				ch.first  = HW_ADDX | (ra << 16);
				ch.second = HW_STR | rc | (rb << 16);
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_ADD: begin
				ch.first  = HW_ADD | ra | (rb << 5) | (rc << 16);
				ch.second = HW_NOP;
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_MUL: begin
				ch.first  = HW_MADD | ra | (rb << 5) | (rc << 16) | (32'd31 << 10);
				ch.second = HW_NOP;
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_DIV: begin
				ch.first  = HW_UDIV | ra | (rb << 5) | (rc << 16);
				ch.second = HW_NOP;
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_NAND: begin
				ch.first  = HW_AND | HR_SCRATCH | (rb << 5) | (rc << 16);
				ch.second = HW_MVN | ra | (HR_SCRATCH << 16);
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_HALT: begin
				ch.first  = service_mov(c.halt_code, c.service_reg);
				ch.second = HW_BR_X15;
			end
			umt_pkg::OP_MAP: begin
				ch.first  = HW_MOV | (rc << 16);
				ch.second = HW_BLR_X12;
				ch.third  = HW_MOV | rb;
			end
			umt_pkg::OP_UNMAP: begin
				ch.first  = HW_MOV | (rc << 16);
				ch.second = HW_BLR_X13;
				ch.third  = HW_NOP;
			end
			umt_pkg::OP_OUTPUT: begin
				ch.first  = HW_MOV | (rc << 16);
				ch.second = service_mov(c.output_code, c.service_reg);
				ch.third  = HW_BLR_X15;
			end
			umt_pkg::OP_INPUT: begin
				ch.first  = service_mov(c.input_code, c.service_reg);
				ch.second = HW_BLR_X15;
				ch.third  = HW_MOV | rc;
			end
			umt_pkg::OP_LOADP: begin
				ch.first  = HW_MOV_W10 | (rc << 16);
				ch.second = HW_MOV | (rb << 16);
				ch.third  = HW_BR_X15;
			end
			default: begin
				// Invalid opcodes leave all three words at zero.
			end
		endcase
		return ch;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Sender: offers queued UM words, predicting each accepted transaction.
	always @(posedge clk or negedge arst_n) begin : drive_um_in
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_word  <= '0;
		end else begin
			if (in_valid && um_in.ready) begin
				host_chunks_due.push_back(translate_um(in_word, cfg_model));
				words_taken <= words_taken + 1;
			end
			if (!in_valid || um_in.ready) begin
				if (send_gap != 0) begin
					in_valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (um_words_pending.size() != 0) begin
					in_valid <= 1'b1;
					in_word  <= um_words_pending.pop_front();
					if (send_calm != 0) begin
						send_calm <= send_calm - 1;
					end else begin
						send_gap <= pick_gap();
						if ($urandom_range(0, 39) == 0)
							send_calm <= 50;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, calm stretches, and one long hold-off.
	always @(posedge clk or negedge arst_n) begin : drive_host_ready
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (!held_off && results_seen >= HOLD_AT) begin
			held_off   <= 1'b1;
			out_ready  <= 1'b0;
			recv_stall <= HOLD_CYCLES;
		end else if (recv_stall != 0) begin
			out_ready  <= 1'b0;
			recv_stall <= recv_stall - 1;
		end else begin
			out_ready <= 1'b1;
			if (recv_calm != 0)
				recv_calm <= recv_calm - 1;
			else if ($urandom_range(0, 99) < 30)
				recv_stall <= pick_gap();
			else if ($urandom_range(0, 59) == 0)
				recv_calm <= 50;
		end
	end

	task automatic check_word(input string field, input logic [31:0] um_word,
		input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			errors++;
			if (errors <= REPORT_MAX)
				$display("Mismatch on %s for UM word %h: expected %h, got %h",
					field, um_word, want, got);
		end
	endtask

	// Monitor: compares each chunk transaction with the oldest prediction.
	always @(posedge clk) begin : check_host_out
		host_chunk_t want;
		if (arst_n && host_out.valid && out_ready) begin
			results_seen <= results_seen + 1;
			if (host_chunks_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("Unexpected chunk %h %h %h with nothing outstanding",
						host_out.host_word_first, host_out.host_word_second,
						host_out.host_word_third);
			end else begin
				want = host_chunks_due.pop_front();
				check_word("host_word_first", want.um_word, want.first,
					host_out.host_word_first);
				check_word("host_word_second", want.um_word, want.second,
					host_out.host_word_second);
				check_word("host_word_third", want.um_word, want.third,
					host_out.host_word_third);
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && um_in.ready) || (host_out.valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Waits until every queued word has been taken and every chunk checked.
	// The check runs at the falling edge, after the driver's updates settle.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (um_words_pending.size() != 0 || in_valid || host_chunks_due.size() != 0);
	endtask

	// One register write; the enable stays high across back-to-back writes.
	task automatic write_cfg(input logic [2:0] idx, input logic [4:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			umt_pkg::CFG_REG_BASE:    cfg_model.reg_base    = data;
			umt_pkg::CFG_HALT_CODE:   cfg_model.halt_code   = data[2:0];
			umt_pkg::CFG_OUTPUT_CODE: cfg_model.output_code = data[2:0];
			umt_pkg::CFG_INPUT_CODE:  cfg_model.input_code  = data[2:0];
			umt_pkg::CFG_SERVICE_REG: cfg_model.service_reg = data;
			default: begin
				// Writes past the register list change nothing.
			end
		endcase
	endtask

	// Writes all five registers, then a stray write past the list.
	task automatic apply_setting(input logic [4:0] base, input logic [4:0] halt,
		input logic [4:0] outc, input logic [4:0] inc, input logic [4:0] svc);
		logic [2:0] spare;
		spare = CFG_FIRST_UNUSED + 3'($urandom_range(0, 2));
		write_cfg(umt_pkg::CFG_REG_BASE, base);
		write_cfg(umt_pkg::CFG_HALT_CODE, halt);
		write_cfg(umt_pkg::CFG_OUTPUT_CODE, outc);
		write_cfg(umt_pkg::CFG_INPUT_CODE, inc);
		write_cfg(umt_pkg::CFG_SERVICE_REG, svc);
		write_cfg(spare, 5'($urandom_range(0, 31)));
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int k;
		int ph;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words under reset configuration: every opcode value with all
		// fields and ignored bits set, then zero fields and immediate extremes.
		for (k = 0; k < 16; k++)
			um_words_pending.push_back({4'(k), 28'hFFF_FFFF});
		um_words_pending.push_back({umt_pkg::OP_CMOV, 28'h000_0000});
		um_words_pending.push_back({umt_pkg::OP_HALT, 28'h000_0000});
		um_words_pending.push_back({umt_pkg::OP_LOADV, 28'h000_0000});
		um_words_pending.push_back({umt_pkg::OP_LOADV, 3'b000, 25'h1FF_FFFF});
		um_words_pending.push_back({umt_pkg::OP_LOADV, 3'b111, 25'h000_0000});
		um_words_pending.push_back({umt_pkg::OP_NAND, 19'h0_0000, 9'o765});
		wait_drained();

		// Random phases, each under a new configuration.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: apply_setting(5'd0, 5'd0, 5'd0, 5'd0, 5'd0);
				1: apply_setting(5'd24, 5'd7, 5'd7, 5'd7, 5'd31);
				// Base of 31 so that every nonzero field wraps past register 31.
				2: apply_setting(5'd31, 5'h18, 5'h15, 5'h0B, 5'd0);
				3: apply_setting(5'd19, 5'd0, 5'd1, 5'd2, 5'd1);
				default: apply_setting(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
					5'($urandom_range(0, 31)));
			endcase
			for (k = 0; k < PHASE_ITEMS; k++)
				um_words_pending.push_back($urandom());
			wait_drained();
		end

		repeat (6) @(posedge clk);
		if (host_chunks_due.size() != 0)
			errors++;
		$display("Run covered %0d UM words and %0d chunks over %0d register settings.",
			words_taken, results_seen, settings_used);
		$display("Receiver hold-off of %0d cycles exercised: %0s; mismatches: %0d.",
			HOLD_CYCLES, held_off ? "yes" : "no", errors);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
